### sv/ols_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list store package
// Command codes, result status codes, controller states and the command
// group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ols_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK    = 3'd0,
    CMD_PUSH_FRONT   = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_BACK  = 3'd3,
    CMD_INSERT_AFTER = 3'd4,
    CMD_READ_ALL     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // apply the accepted command and load its acknowledge
    logic load_elem;  // load one element of a read-out into the result register
  } dp_cmd_t;

endpackage

### sv/ols_if.sv
// ----------------------------------------------------------------------------
// Ordered list store channels
// Command channel and response channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ols_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] item_value;
  logic [6:0]         position;

  modport source (output valid, output cmd, output item_value, output position,
                  input ready);
  modport sink   (input valid, input cmd, input item_value, input position,
                  output ready);
endinterface

interface ols_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic               last;
  logic [6:0]         count;

  modport source (output valid, output out_value, output status, output last,
                  output count, input ready);
  modport sink   (input valid, input out_value, input status, input last,
                  input count, output ready);
endinterface

### sv/ols_datapath.sv
// ----------------------------------------------------------------------------
// Ordered list store datapath
// Shifting element cells, element count and the registered result payload.
// ----------------------------------------------------------------------------
module ols_datapath
  import ols_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            dp_cmd,
  input  logic [IW-1:0]      elem_idx,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] item_value,
  input  logic [6:0]         position,
  output logic [CW-1:0]      count,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last,
  output logic [6:0]         out_count
);

  logic signed [31:0] cells [DEPTH];
  logic               full;
  logic               empty;
  logic               ins_en;
  logic               rem_front;
  logic               rem_any;
  logic [IW-1:0]      ins_idx;
  logic [CW-1:0]      count_next;
  status_t            exec_status;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ins_en      = 1'b0;
    rem_front   = 1'b0;
    rem_any     = 1'b0;
    ins_idx     = '0;
    exec_status = STAT_OK;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          exec_status = STAT_FULL;
        end else begin
          ins_en  = 1'b1;
          ins_idx = IW'(count);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          exec_status = STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      CMD_REMOVE_FRONT: begin
        if (empty) begin
          exec_status = STAT_EMPTY;
        end else begin
          rem_front = 1'b1;
          rem_any   = 1'b1;
        end
      end
      CMD_REMOVE_BACK: begin
        if (empty) begin
          exec_status = STAT_EMPTY;
        end else begin
          rem_any = 1'b1;
        end
      end
      CMD_INSERT_AFTER: begin
        if (full) begin
          exec_status = STAT_FULL;
        end else if (position == '0 || position > 7'(count)) begin
          exec_status = STAT_RANGE;
        end else begin
          ins_en  = 1'b1;
          ins_idx = IW'(position);
        end
      end
      CMD_READ_ALL: begin
        if (empty) begin
          exec_status = STAT_EMPTY;
        end
      end
      default: begin
      end
    endcase

    count_next = count;
    if (ins_en) begin
      count_next = count + CW'(1);
    end else if (rem_any) begin
      count_next = count - CW'(1);
    end
  end

  // Each cell picks its own next value: keep, take the new value, take its
  // front neighbor (insert) or take its back neighbor (remove front).
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ins_en) begin
          if (IW'(i) == ins_idx) begin
            cells[i] <= item_value;
          end else if (IW'(i) > ins_idx) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (rem_front && i < DEPTH - 1) begin
          cells[i] <= cells[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      out_value <= '0;
      status    <= exec_status;
      last      <= 1'b1;
      out_count <= 7'(count_next);
    end else if (dp_cmd.load_elem) begin
      out_value <= cells[elem_idx];
      status    <= STAT_OK;
      last      <= (CW'(elem_idx) + CW'(1) == count);
      out_count <= 7'(count);
    end
  end

endmodule

### sv/ols_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list store controller
// Handshake control, read-out sequencing and result valid flag.
// ----------------------------------------------------------------------------
module ols_ctrl
  import ols_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [2:0]    cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  logic [CW-1:0] count,
  output dp_cmd_t       dp_cmd,
  output logic [IW-1:0] elem_idx
);

  state_t        state;
  state_t        state_next;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] rd_idx_next;
  logic          out_free;
  logic          accept;
  logic          start_read;
  logic          rd_done;

  // The result register can take a new item when empty or being drained.
  assign out_free   = !rsp_valid || rsp_ready;
  assign accept     = req_valid && req_ready;
  assign start_read = (cmd == CMD_READ_ALL) && (count != '0);
  assign rd_done    = (CW'(rd_idx) == count - CW'(1));

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept && start_read && count != CW'(1)) begin
          state_next  = ST_READ;
          rd_idx_next = IW'(1);
        end
      end
      ST_READ: begin
        if (out_free) begin
          if (rd_done) begin
            state_next = ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + IW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready        = 1'b0;
    dp_cmd.exec      = 1'b0;
    dp_cmd.load_elem = 1'b0;
    elem_idx         = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready        = out_free;
        dp_cmd.exec      = accept && !start_read;
        dp_cmd.load_elem = accept && start_read;
      end
      ST_READ: begin
        dp_cmd.load_elem = out_free;
        elem_idx         = rd_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_idx    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (dp_cmd.exec || dp_cmd.load_elem) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/ordered_list_store.sv
// ----------------------------------------------------------------------------
// Ordered list store, top level
// A result is registered in the cycle after its command item is accepted.
// Throughput, while the result register is free: one command per cycle, or
// during read-all one element per cycle, set by the single read port on cells.
// Reset clears the element count and the handshake state; cells are not reset.
// ----------------------------------------------------------------------------
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  ols_cmd_if.sink   req,
  ols_rsp_if.source rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t       dp_cmd;
  logic [IW-1:0] elem_idx;
  logic [CW-1:0] count;

  ols_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .count     (count),
    .dp_cmd    (dp_cmd),
    .elem_idx  (elem_idx)
  );

  ols_datapath #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .elem_idx   (elem_idx),
    .cmd        (req.cmd),
    .item_value (req.item_value),
    .position   (req.position),
    .count      (count),
    .out_value  (rsp.out_value),
    .status     (rsp.status),
    .last       (rsp.last),
    .out_count  (rsp.count)
  );

endmodule

### dv/ordered_list_store_tb.sv
// ----------------------------------------------------------------------------
// Ordered list store testbench
// Drives a short table of directed commands, then random command streams that fill
// and drain the list; sender and receiver idle at random save in the last phase.
// Every response item is compared against a behavioral model of the list.
// ----------------------------------------------------------------------------
module ordered_list_store_tb;
  import ols_pkg::*;

  localparam int DEPTH = 16;
  localparam int NRAND = 231;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  // Command codes that the block answers with a plain acknowledge.
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            st;
    logic               last;
    logic [6:0]         cnt;
  } rsp_item_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic [6:0]         pos;
    int                 reps;
    bit                 typed;
    logic signed [31:0] e_val;
    status_t            e_st;
    logic               e_last;
    logic [6:0]         e_cnt;
  } plan_row_t;

  localparam int NPLAN = 24;

  plan_row_t plan [0:NPLAN-1] = '{
    '{CMD_REMOVE_FRONT, 32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_EMPTY, 1'b1, 7'd0},
    '{CMD_REMOVE_BACK,  32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_EMPTY, 1'b1, 7'd0},
    '{CMD_READ_ALL,     32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_EMPTY, 1'b1, 7'd0},
    '{CMD_INSERT_AFTER, 32'sd5,    7'd1,  1,  1'b1, 32'sd0, STAT_RANGE, 1'b1, 7'd0},
    '{CMD_PUSH_BACK,    VAL_MAX,   7'd0,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd1},
    '{CMD_PUSH_FRONT,   VAL_MIN,   7'd0,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd2},
    '{CMD_INSERT_AFTER, 32'sd7,    7'd0,  1,  1'b1, 32'sd0, STAT_RANGE, 1'b1, 7'd2},
    '{CMD_INSERT_AFTER, 32'sd7,    7'd3,  1,  1'b1, 32'sd0, STAT_RANGE, 1'b1, 7'd2},
    '{CMD_INSERT_AFTER, -32'sd1,   7'd64, 1,  1'b1, 32'sd0, STAT_RANGE, 1'b1, 7'd2},
    '{CMD_INSERT_AFTER, -32'sd1,   7'd2,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd3},
    '{CMD_INSERT_AFTER, 32'sd0,    7'd1,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd4},
    '{CMD_READ_ALL,     32'sd0,    7'd0,  1,  1'b0, 32'sd0, STAT_OK,    1'b0, 7'd0},
    '{CMD_UNUSED_6,     32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd4},
    '{CMD_UNUSED_7,     -32'sd1,   7'd64, 1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd4},
    '{CMD_REMOVE_FRONT, 32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd3},
    '{CMD_REMOVE_BACK,  32'sd0,    7'd0,  1,  1'b1, 32'sd0, STAT_OK,    1'b1, 7'd2},
    '{CMD_READ_ALL,     32'sd0,    7'd0,  1,  1'b0, 32'sd0, STAT_OK,    1'b0, 7'd0},
    '{CMD_PUSH_BACK,    32'sh5A5A_A5A5, 7'd0, 14, 1'b0, 32'sd0, STAT_OK, 1'b0, 7'd0},
    '{CMD_PUSH_BACK,    32'sd9,    7'd0,  1,  1'b1, 32'sd0, STAT_FULL,  1'b1, 7'd16},
    '{CMD_PUSH_FRONT,   32'sd9,    7'd0,  1,  1'b1, 32'sd0, STAT_FULL,  1'b1, 7'd16},
    '{CMD_INSERT_AFTER, 32'sd9,    7'd0,  1,  1'b1, 32'sd0, STAT_FULL,  1'b1, 7'd16},
    '{CMD_INSERT_AFTER, 32'sd9,    7'd16, 1,  1'b1, 32'sd0, STAT_FULL,  1'b1, 7'd16},
    '{CMD_READ_ALL,     32'sd0,    7'd0,  1,  1'b0, 32'sd0, STAT_OK,    1'b0, 7'd0},
    '{CMD_REMOVE_FRONT, 32'sd0,    7'd0,  3,  1'b0, 32'sd0, STAT_OK,    1'b0, 7'd0}
  };

  logic clk;
  logic rst;

  ols_cmd_if req ();
  ols_rsp_if rsp ();

  ordered_list_store #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Model of the list contents, index 0 is the front.
  logic signed [31:0] cells [DEPTH];
  int unsigned        held;
  rsp_item_t          pending_rsp [$];
  rsp_item_t          oldest;
  int                 n_fail;
  int                 phase;
  int                 stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int send_idle_pct();
    return (phase == 0) ? 34 : (phase == 1) ? 46 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (phase == 0) ? 46 : (phase == 1) ? 34 : 0;
  endfunction

  // Appends one expected response item at the tail of the queue.
  function automatic void expect_item(rsp_item_t item);
    pending_rsp = {pending_rsp, item};
  endfunction

  // Applies one command to the list model and queues the response items it causes.
  function automatic void predict_results(logic [2:0] op, logic signed [31:0] val,
                                          logic [6:0] pos);
    status_t st;
    int      slot;
    st   = STAT_OK;
    slot = -1;
    case (op) inside
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (held >= DEPTH) st = STAT_FULL;
        else slot = (op == CMD_PUSH_BACK) ? int'(held) : 0;
      end
      CMD_REMOVE_FRONT: begin
        if (held == 0) st = STAT_EMPTY;
        else begin
          for (int i = 1; i < held; i++) cells[i-1] = cells[i];
          held--;
        end
      end
      CMD_REMOVE_BACK: begin
        if (held == 0) st = STAT_EMPTY;
        else held--;
      end
      CMD_INSERT_AFTER: begin
        if (held >= DEPTH) st = STAT_FULL;
        else if (pos == 0 || pos > held) st = STAT_RANGE;
        else slot = int'(pos);
      end
      CMD_READ_ALL: begin
        if (held == 0) expect_item('{32'sd0, STAT_EMPTY, 1'b1, 7'd0});
        for (int i = 0; i < held; i++)
          expect_item('{cells[i], STAT_OK, (i + 1 == held), 7'(held)});
        return;
      end
      default: ;
    endcase
    if (slot >= 0) begin
      for (int i = int'(held); i > slot; i--) cells[i] = cells[i-1];
      cells[slot] = val;
      held++;
    end
    expect_item('{32'sd0, st, 1'b1, 7'(held)});
  endfunction

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] val,
                           input logic [6:0] pos);
    while ($urandom_range(99) < send_idle_pct()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.cmd        <= op;
    req.item_value <= val;
    req.position   <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_results(op, val, pos);
  endtask

  // Holds the command channel idle until every queued response item has arrived.
  task automatic pause_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response item with nothing expected: value %0d status %0d",
               rsp.out_value, rsp.status);
        n_fail++;
      end else begin
        oldest = pending_rsp.pop_front();
        if (rsp.out_value !== oldest.value) begin
          $error("out_value: expected %0d, actual %0d", oldest.value, rsp.out_value);
          n_fail++;
        end
        if (rsp.status !== oldest.st) begin
          $error("status: expected %0d, actual %0d", oldest.st, rsp.status);
          n_fail++;
        end
        if (rsp.last !== oldest.last) begin
          $error("last: expected %0d, actual %0d", oldest.last, rsp.last);
          n_fail++;
        end
        if (rsp.count !== oldest.cnt) begin
          $error("count: expected %0d, actual %0d", oldest.cnt, rsp.count);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]         op;
    logic signed [31:0] val;
    logic [6:0]         pos;
    int                 r;
    bit                 growing;
    req.valid      = 1'b0;
    req.cmd        = 3'd0;
    req.item_value = 32'sd0;
    req.position   = 7'd0;
    rst            = 1'b1;
    held           = 0;
    n_fail         = 0;
    phase          = 0;
    stall_cycles   = 0;
    growing        = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_item(plan[i].op, plan[i].val ^ k, plan[i].pos);
        if (plan[i].typed)
          pending_rsp[pending_rsp.size()-1] =
            '{plan[i].e_val, plan[i].e_st, plan[i].e_last, plan[i].e_cnt};
      end
    end

    for (int i = 0; i < NRAND; i++) begin
      if (i * 3 / NRAND != phase || $urandom_range(49) == 0) begin
        pause_until_drained();
        phase = i * 3 / NRAND;
      end
      // Swing between filling and draining so both the full and the empty
      // list are reached many times.
      if (held == DEPTH) growing = 1'b0;
      else if (held == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 5) op = ($urandom_range(1) != 0) ? CMD_UNUSED_7 : CMD_UNUSED_6;
      else if (r < 13) op = CMD_READ_ALL;
      else if ($urandom_range(99) < (growing ? 75 : 25)) begin
        case ($urandom_range(2))
          0:       op = CMD_PUSH_BACK;
          1:       op = CMD_PUSH_FRONT;
          default: op = CMD_INSERT_AFTER;
        endcase
      end else begin
        op = ($urandom_range(1) != 0) ? CMD_REMOVE_BACK : CMD_REMOVE_FRONT;
      end
      case ($urandom_range(7))
        0:       val = VAL_MAX;
        1:       val = VAL_MIN;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom();
      endcase
      if (held != 0 && $urandom_range(9) < 8) pos = 7'($urandom_range(held, 1));
      else pos = 7'($urandom_range(64));
      send_item(op, val, pos);
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
